/* rtl/dss_pkg.sv */
// Shared types and constants of the drive supervisor.
`default_nettype none

package dss_pkg;

   // Supervisor state codes
   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_CALIB   = 3'd1;
   localparam logic [2:0] ST_STANDBY = 3'd2;
   localparam logic [2:0] ST_OPER    = 3'd3;
   localparam logic [2:0] ST_ERROR   = 3'd4;
   localparam logic [2:0] ST_ESTOP   = 3'd5;

   // Operation codes
   localparam logic [1:0] OP_UPDATE     = 2'd0;
   localparam logic [1:0] OP_TRANSITION = 2'd1;
   localparam logic [1:0] OP_SET_REQ    = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_CRIT_MASK    = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_MASK = 2'd1;
   localparam logic [1:0] CSR_INIT_DELAY   = 2'd2;

   localparam logic [31:0] INIT_DELAY_RESET = 32'd2000;

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;

   // Result word, lowest bits last
   typedef struct packed {
      logic       pad;
      logic       estop_pulse;
      logic       drive_enable;
      logic       changed;
      logic       accepted;
      logic [2:0] current_state;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/drive_supervisor_state_machine_core.sv */
// Drive supervisor: six-state machine with a registered, skid-buffered result stream.
`default_nettype none

// Channel   Direction  Payload
// req_*     in         tdata: now_ms, active_errors, error_reset, target_state, requested
//                      tuser: operation
// rsp_*     out        tdata: current_state, accepted, changed, drive_enable, estop_pulse
// csr_*     in         csr_index, csr_data (register write)
//
// One request per cycle while req_tready is high; each result is registered before rsp_*.
// The state update is a single pass: one 32-bit subtract/compare plus the
// transition table, settled in the cycle the request is accepted.
// A two-deep result buffer (output register plus skid) keeps req_tready high
// while one result waits; req_tready drops only when both are full.
// Synchronous reset returns to initializing, entry time 0, masks 0, delay 2000.

module drive_supervisor_state_machine_core
   import dss_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [31:0] now_ms, [63:32] active_errors, [64] error_reset,
   // [67:65] target_state, [68] requested, [71:69] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] current_state, [3] accepted, [4] changed, [5] drive_enable,
   // [6] estop_pulse, [7] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [31:0]           csr_data
);

   typedef enum logic [2:0] {
      S_INIT    = ST_INIT,
      S_CALIB   = ST_CALIB,
      S_STANDBY = ST_STANDBY,
      S_OPER    = ST_OPER,
      S_ERROR   = ST_ERROR,
      S_ESTOP   = ST_ESTOP
   } sup_state_type;

   // Allowed-move table; self moves and unused codes are refused
   function automatic logic allowed(input sup_state_type from, input logic [2:0] to);
      logic ok;
      case (from)
         S_INIT, S_CALIB: ok = (to == ST_STANDBY) || (to == ST_ERROR);
         S_STANDBY:       ok = (to == ST_OPER) || (to == ST_CALIB) ||
                               (to == ST_ERROR) || (to == ST_ESTOP);
         S_OPER:          ok = (to == ST_STANDBY) || (to == ST_ERROR) ||
                               (to == ST_ESTOP);
         S_ERROR:         ok = (to == ST_STANDBY) || (to == ST_ESTOP);
         S_ESTOP:         ok = (to == ST_INIT);
         default:         ok = 1'b0;
      endcase
      return ok;
   endfunction

   // Configuration registers
   logic [31:0] crit_mask_ff;
   logic [31:0] timeout_mask_ff;
   logic [31:0] init_delay_ff;

   // Supervisor state
   sup_state_type state_ff, state_in;
   logic [31:0]   entry_ff, entry_in;
   logic          oper_req_ff, oper_req_in;

   // Result buffer
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;

   // Request fields
   logic [1:0]  op;
   logic [31:0] now_ms;
   logic [31:0] errs;
   logic        ereset;
   logic [2:0]  target;
   logic        requested;

   assign op        = req_tuser[1:0];
   assign now_ms    = req_tdata[31:0];
   assign errs      = req_tdata[63:32];
   assign ereset    = req_tdata[64];
   assign target    = req_tdata[67:65];
   assign requested = req_tdata[68];

   logic        req_take, rsp_take;
   logic [31:0] elapsed;
   logic        crit_hit, timeout_hit, delay_done;
   logic        go_valid;
   logic [2:0]  go_state;
   logic        changed;
   rsp_type     result;

   assign req_tready = !skid_valid_ff;
   assign csr_ready  = 1'b1;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   assign elapsed     = now_ms - entry_ff;
   assign delay_done  = elapsed > init_delay_ff;
   assign crit_hit    = |(errs & crit_mask_ff);
   assign timeout_hit = |(errs & timeout_mask_ff);

   // Pick the candidate move for this request
   always_comb begin
      go_valid = 1'b0;
      go_state = ST_INIT;
      case (op)
         OP_UPDATE: begin
            case (state_ff)
               S_INIT: begin
                  if (delay_done && (errs == '0)) begin
                     go_valid = 1'b1;
                     go_state = ST_STANDBY;
                  end else if (errs != '0) begin
                     go_valid = 1'b1;
                     go_state = ST_ERROR;
                  end
               end
               S_STANDBY: begin
                  if (crit_hit) begin
                     go_valid = 1'b1;
                     go_state = ST_ERROR;
                  end else if (oper_req_ff && !ereset) begin
                     go_valid = 1'b1;
                     go_state = ST_OPER;
                  end
               end
               S_OPER: begin
                  if (crit_hit) begin
                     go_valid = 1'b1;
                     go_state = ST_ERROR;
                  end else if (timeout_hit) begin
                     go_valid = 1'b1;
                     go_state = ST_STANDBY;
                  end
               end
               S_ERROR: begin
                  if (ereset && !crit_hit) begin
                     go_valid = 1'b1;
                     go_state = ST_STANDBY;
                  end
               end
               default: ;
            endcase
         end
         OP_TRANSITION: begin
            go_valid = 1'b1;
            go_state = target;
         end
         default: ;
      endcase
   end

   assign changed = go_valid && allowed(state_ff, go_state);

   always_comb begin
      state_in    = state_ff;
      entry_in    = entry_ff;
      oper_req_in = oper_req_ff;
      if (changed) begin
         state_in = sup_state_type'(go_state);
         entry_in = now_ms;
         if (go_state == ST_OPER) oper_req_in = 1'b0;
      end
      if (op == OP_SET_REQ) oper_req_in = requested;
   end

   always_comb begin
      result               = '0;
      result.current_state = state_in;
      result.accepted      = changed && (op == OP_TRANSITION);
      result.changed       = changed;
      result.drive_enable  = (state_in == S_OPER);
      result.estop_pulse   = changed && (state_in == S_ESTOP);
   end

   // State and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         entry_ff        <= '0;
         oper_req_ff     <= 1'b0;
         crit_mask_ff    <= '0;
         timeout_mask_ff <= '0;
         init_delay_ff   <= INIT_DELAY_RESET;
      end else begin
         if (req_take) begin
            state_ff    <= state_in;
            entry_ff    <= entry_in;
            oper_req_ff <= oper_req_in;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_CRIT_MASK:    crit_mask_ff    <= csr_data;
               CSR_TIMEOUT_MASK: timeout_mask_ff <= csr_data;
               CSR_INIT_DELAY:   init_delay_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Output register with skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_take) begin
            if (!out_valid_ff || rsp_take) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) out_data_ff <= skid_data_ff;
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) out_data_ff  <= result;
         else                           skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

/* rtl/dss_checker.sv */
// Port-level checks of the drive supervisor and their bind.
`default_nettype none

module dss_checker
   import dss_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_tdata;

   // Drive enable mirrors the reported state
   a_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.drive_enable == (rsp.current_state == ST_OPER)))
      else $error("drive_enable disagrees with current_state");

   // Stop pulse only on a move into emergency stop
   a_estop: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.estop_pulse) |-> (rsp.changed && rsp.current_state == ST_ESTOP))
      else $error("estop_pulse without entry into emergency stop");

   // An accepted request is always a state change
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.accepted) |-> rsp.changed)
      else $error("accepted without changed");

   // Ready only drops while a result is waiting
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no result pending");

   // Reset empties the result buffer
   a_reset: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result buffer not empty after reset");

endmodule

bind drive_supervisor_state_machine_core dss_checker u_dss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/sv/dss_scoreboard_pkg.sv */
// Scoreboard class for the drive supervisor bench: state prediction and status checking.
package dss_scoreboard_pkg;
   import dss_pkg::*;

   class supervisor_scoreboard;
      logic [31:0] crit_mask;
      logic [31:0] timeout_mask;
      logic [31:0] init_delay;
      logic [2:0]  present;
      logic [31:0] entry_ms;
      logic        oper_req;
      rsp_type     pending_status[$];
      int unsigned mismatches;

      function new();
         crit_mask    = '0;
         timeout_mask = '0;
         init_delay   = INIT_DELAY_RESET;
         present      = ST_INIT;
         entry_ms     = '0;
         oper_req     = 1'b0;
         mismatches   = 0;
      endfunction

      // Output is capped so a badly broken build cannot flood the log
      function void report(string msg);
         if (mismatches < 200) $display("mismatch: %s", msg);
         mismatches++;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            CSR_CRIT_MASK:    crit_mask = value;
            CSR_TIMEOUT_MASK: timeout_mask = value;
            CSR_INIT_DELAY:   init_delay = value;
            default: ;
         endcase
      endfunction

      function bit legal_move(logic [2:0] from_st, logic [2:0] to_st);
         case (from_st)
            ST_INIT, ST_CALIB: return to_st == ST_STANDBY || to_st == ST_ERROR;
            ST_STANDBY: return to_st == ST_OPER || to_st == ST_CALIB ||
                               to_st == ST_ERROR || to_st == ST_ESTOP;
            ST_OPER:    return to_st == ST_STANDBY || to_st == ST_ERROR || to_st == ST_ESTOP;
            ST_ERROR:   return to_st == ST_STANDBY || to_st == ST_ESTOP;
            ST_ESTOP:   return to_st == ST_INIT;
            default:    return 1'b0;
         endcase
      endfunction

      function bit move_to(logic [2:0] to_st, logic [31:0] now);
         if (!legal_move(present, to_st)) return 1'b0;
         present  = to_st;
         entry_ms = now;
         if (to_st == ST_OPER) oper_req = 1'b0;
         return 1'b1;
      endfunction

      // Advance the predicted supervisor by one accepted request
      function void note_request(logic [1:0] op, logic [REQ_DATA_W-1:0] data);
         logic [31:0] now;
         logic [31:0] errs;
         logic [31:0] elapsed;
         logic        ereset;
         logic [2:0]  target;
         logic        want;
         bit          accepted;
         bit          changed;
         rsp_type     status;
         now      = data[31:0];
         errs     = data[63:32];
         ereset   = data[64];
         target   = data[67:65];
         want     = data[68];
         accepted = 1'b0;
         changed  = 1'b0;
         case (op)
            OP_UPDATE: begin
               elapsed = now - entry_ms;
               case (present)
                  ST_INIT: begin
                     if (elapsed > init_delay && errs == '0) changed = move_to(ST_STANDBY, now);
                     else if (errs != '0) changed = move_to(ST_ERROR, now);
                  end
                  ST_STANDBY: begin
                     if ((errs & crit_mask) != '0) changed = move_to(ST_ERROR, now);
                     else if (oper_req && !ereset) changed = move_to(ST_OPER, now);
                  end
                  ST_OPER: begin
                     if ((errs & crit_mask) != '0) changed = move_to(ST_ERROR, now);
                     else if ((errs & timeout_mask) != '0) changed = move_to(ST_STANDBY, now);
                  end
                  ST_ERROR: begin
                     if (ereset && (errs & crit_mask) == '0) changed = move_to(ST_STANDBY, now);
                  end
                  default: ;
               endcase
            end
            OP_TRANSITION: begin
               accepted = move_to(target, now);
               changed  = accepted;
            end
            OP_SET_REQ: oper_req = want;
            default: ;
         endcase
         status.pad           = 1'b0;
         status.estop_pulse   = changed && present == ST_ESTOP;
         status.drive_enable  = present == ST_OPER;
         status.changed       = changed;
         status.accepted      = accepted;
         status.current_state = present;
         pending_status.push_back(status);
      endfunction

      function void check_status(logic [RSP_DATA_W-1:0] word);
         rsp_type got;
         rsp_type want_st;
         got = word;
         if (pending_status.size() == 0) begin
            report($sformatf("status %h with no request outstanding", word));
            return;
         end
         want_st = pending_status.pop_front();
         if (got.current_state !== want_st.current_state)
            report($sformatf("current_state %0d, expected %0d",
                             got.current_state, want_st.current_state));
         if (got.accepted !== want_st.accepted)
            report($sformatf("accepted %b, expected %b", got.accepted, want_st.accepted));
         if (got.changed !== want_st.changed)
            report($sformatf("changed %b, expected %b", got.changed, want_st.changed));
         if (got.drive_enable !== want_st.drive_enable)
            report($sformatf("drive_enable %b, expected %b",
                             got.drive_enable, want_st.drive_enable));
         if (got.estop_pulse !== want_st.estop_pulse)
            report($sformatf("estop_pulse %b, expected %b",
                             got.estop_pulse, want_st.estop_pulse));
         if (got.pad !== 1'b0)
            report($sformatf("pad bit %b, expected 0", got.pad));
      endfunction

      function void check_drained();
         if (pending_status.size() != 0)
            report($sformatf("%0d status words never arrived", pending_status.size()));
      endfunction
   endclass

endpackage

/* tb/sv/drive_supervisor_state_machine_core_tb.sv */
// Self-checking bench for the drive supervisor core: directed walk, then randomised phases.
module drive_supervisor_state_machine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dss_pkg::*;
   import dss_scoreboard_pkg::*;

   // Codes the block must tolerate but that carry no behaviour
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [2:0] ST_UNUSED_LO = 3'd6;
   localparam logic [2:0] ST_UNUSED_HI = 3'd7;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   wire                   csr_ready;
   logic [1:0]            csr_index  = '0;
   logic [31:0]           csr_data   = '0;

   // When set, neither side inserts gaps or stalls
   logic                  steady     = 1'b0;
   // Millisecond timestamp fed to the requests, stepped once per request
   logic [31:0]           clock_ms   = '0;

   supervisor_scoreboard  sb = new();

   drive_supervisor_state_machine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #1_000_000;
      $display("drive_supervisor_state_machine_core regression: fail");
      $finish;
   end

   // Status sink: values seen here are the ones from before this edge, so the
   // check never races the block's own update. Back-pressure about one cycle
   // in ten unless a steady phase is running.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
      rsp_tready <= steady || ($urandom_range(99) >= 10);
   end

   // One request on the input channel. A gap, when taken, drops tvalid before
   // raising it again in a later step; after acceptance tvalid is left high so
   // the next request can follow back to back.
   task automatic send_request(input logic [1:0] op, input logic [31:0] now,
                               input logic [31:0] errs, input logic ereset,
                               input logic [2:0] target, input logic want);
      if (!steady && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, want, target, ereset, errs, now};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, {3'b000, want, target, ereset, errs, now});
   endtask

   // Register write; csr_valid is left high for a following write and
   // lowered by the caller once the batch is done.
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
   endtask

   task automatic set_registers(input logic [31:0] crit, input logic [31:0] tmo,
                                input logic [31:0] delay);
      write_csr(CSR_CRIT_MASK, crit);
      write_csr(CSR_TIMEOUT_MASK, tmo);
      write_csr(CSR_INIT_DELAY, delay);
      csr_valid <= 1'b0;
   endtask

   // Stop sending and let every outstanding status come back; every request
   // yields one status, so a short tail after that is enough.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return 32'd1 << $urandom_range(31);
         default: return $urandom & $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_delay();
      case ($urandom_range(3))
         0: return $urandom_range(3000);
         1: return $urandom;
         2: return INIT_DELAY_RESET;
         default: return $urandom_range(200);
      endcase
   endfunction

   // Half clean words so the machine can progress; the rest are single bits, mask hits or random
   function automatic logic [31:0] make_errors();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return '0;
         5: return 32'd1 << $urandom_range(31);
         6: return sb.crit_mask & $urandom;
         7: return sb.timeout_mask & $urandom;
         8: return $urandom;
         default: return '1;
      endcase
   endfunction

   // A target the predicted state would likely accept, so transitions actually walk the table
   function automatic logic [2:0] pick_target();
      logic [2:0] t;
      t = 3'($urandom_range(5));
      for (int k = 0; k < 30 && !sb.legal_move(sb.present, t); k++) t = 3'($urandom_range(5));
      return t;
   endfunction

   task automatic run_random(input int count);
      logic [1:0]  op;
      logic [2:0]  target;
      int          r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 40) op = OP_UPDATE;
         else if (r < 75) op = OP_TRANSITION;
         else if (r < 95) op = OP_SET_REQ;
         else op = OP_UNUSED;
         // Mostly small steps, some long ones, the odd jump anywhere (wrap included)
         r = $urandom_range(99);
         if (r < 70) clock_ms = clock_ms + $urandom_range(40);
         else if (r < 90) clock_ms = clock_ms + $urandom_range(5000);
         else clock_ms = $urandom;
         // Land right on the end of the initialising delay now and then
         if (op == OP_UPDATE && $urandom_range(99) < 15)
            clock_ms = sb.entry_ms + sb.init_delay + $urandom_range(1);
         target = ($urandom_range(9) < 7) ? pick_target() : 3'($urandom_range(7));
         send_request(op, clock_ms, make_errors(), $urandom_range(9) < 3, target,
                      $urandom_range(9) < 7);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed walk with the register reset values: masks clear, delay 2000
      send_request(OP_UPDATE, 32'd0, '0, 1'b0, ST_INIT, 1'b0);          // too early
      send_request(OP_TRANSITION, 32'd5, '0, 1'b0, ST_INIT, 1'b0);      // self move
      send_request(OP_TRANSITION, 32'd6, '0, 1'b0, ST_UNUSED_LO, 1'b0); // bad target
      send_request(OP_TRANSITION, 32'd7, '0, 1'b0, ST_UNUSED_HI, 1'b0);
      send_request(OP_UNUSED, '1, '1, 1'b1, ST_UNUSED_HI, 1'b1);        // unused op
      send_request(OP_UPDATE, 32'd2000, '0, 1'b0, ST_INIT, 1'b0);       // delay not passed
      send_request(OP_UPDATE, 32'd2001, '0, 1'b0, ST_INIT, 1'b0);       // to standby
      send_request(OP_SET_REQ, 32'd2002, '0, 1'b0, ST_INIT, 1'b1);
      send_request(OP_UPDATE, 32'd2003, '0, 1'b1, ST_INIT, 1'b0);       // held by reset flag
      send_request(OP_UPDATE, 32'd2004, '0, 1'b0, ST_INIT, 1'b0);       // to operational
      send_request(OP_TRANSITION, 32'd2005, '0, 1'b0, ST_CALIB, 1'b0);  // not allowed
      send_request(OP_UPDATE, 32'd2006, '1, 1'b0, ST_INIT, 1'b0);       // masks clear
      send_request(OP_TRANSITION, 32'd2007, '0, 1'b0, ST_ESTOP, 1'b0);  // stop pulse
      send_request(OP_TRANSITION, 32'd2008, '0, 1'b0, ST_STANDBY, 1'b0);
      send_request(OP_TRANSITION, 32'd2010, '0, 1'b0, ST_INIT, 1'b0);
      send_request(OP_UPDATE, 32'd2011, 32'h8000_0000, 1'b0, ST_INIT, 1'b0); // to error
      send_request(OP_UPDATE, 32'd2012, '1, 1'b1, ST_INIT, 1'b0);       // recovered
      send_request(OP_TRANSITION, 32'd2013, '0, 1'b0, ST_CALIB, 1'b0);
      send_request(OP_UPDATE, 32'd2014, '1, 1'b1, ST_INIT, 1'b1);       // calib ignores it
      send_request(OP_TRANSITION, 32'd2015, '0, 1'b0, ST_STANDBY, 1'b0);
      send_request(OP_UPDATE, 32'd2016, '0, 1'b0, ST_INIT, 1'b0);       // no request pending
      send_request(OP_TRANSITION, 32'd2017, '0, 1'b0, ST_OPER, 1'b0);
      send_request(OP_TRANSITION, 32'd2018, '0, 1'b0, ST_ERROR, 1'b0);
      send_request(OP_TRANSITION, 32'd2019, '0, 1'b0, ST_ESTOP, 1'b0);
      send_request(OP_TRANSITION, 32'hFFFF_FF00, '0, 1'b0, ST_INIT, 1'b0);
      send_request(OP_UPDATE, 32'h0000_0800, '0, 1'b0, ST_INIT, 1'b0);  // elapsed wraps
      wait_idle();

      // Random phases, registers rewritten only while the pipeline is empty.
      // Phase three runs with no gaps or stalls at all.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_registers('0, '0, '0);
            1: set_registers('1, '1, '1);
            2: set_registers('0, '1, $urandom_range(100));    // timeout fallback reachable
            default: set_registers(pick_mask(), pick_mask(), pick_delay());
         endcase
         steady <= (phase == 3);
         run_random(135);
         wait_idle();
      end

      sb.check_drained();
      if (sb.mismatches == 0) begin
         $display("drive_supervisor_state_machine_core regression: pass");
      end else begin
         $display("drive_supervisor_state_machine_core regression: fail");
      end
      $finish;
   end

endmodule
